// ----- rtl/mcips_pkg.sv -----
`default_nettype none

package mcips_pkg;

    // Number of motor channels that carry controller state.
    localparam int CHANNELS = 4;

    // Field and register widths.
    localparam int CH_W     = 2;
    localparam int COUNT_W  = 16;
    localparam int TARGET_W = 24;
    localparam int SPEED_W  = 32;
    localparam int DRIVE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int ACC_W    = 24;
    localparam int ERR_W    = 32;

    // Shared multiplier operand widths: unsigned 16-bit gain as signed 17 bits,
    // and a 34-bit signed operand that holds an error difference.
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = ERR_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1;

    // Stream payload widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 2'd3;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd1280;
    localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd410;
    localparam logic [GAIN_W-1:0]  SCALE_RESET = 16'd985;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16700;

    // Saturate a 33-bit signed difference to the signed 32-bit range.
    function automatic logic signed [ERR_W-1:0] sat32(input logic signed [ERR_W:0] v);
        logic signed [ERR_W-1:0] r;
        if (v[ERR_W] != v[ERR_W-1])
        begin
            r = v[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        end
        else
        begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/multi_channel_incremental_pi_speed.sv -----
// Multi-channel incremental PI speed controller.
// Input stream (s_*): one transaction per measurement. s_tuser carries the
// motor channel, s_tdata the encoder count for one control period and the
// target speed in rpm with 8 fraction bits. Output stream (m_*): one
// transaction per input with the channel, the measured speed (count times
// speed_scale) and the new drive value from the channel's PI accumulator.
// The arithmetic runs through one shared 17x34 multiplier under a small
// sequencer that steps an item through SPD, ERR, DIFF, KP, KI, SUM, CLAMP
// and DONE to the output register; a new item is accepted only in idle. The
// three products (count times scale, kp times the error change, ki times
// the error) take their turn on that multiplier. The output register lets
// the next item be accepted while a result still waits; if the receiver
// stalls longer, the finished item waits in the last step until the output
// register frees. Configuration writes (cfg_wen, cfg_index, cfg_data) take
// effect at once; the user must see that they are made only while the block is idle,
// which the block itself does not enforce. Reset restores the default gains,
// scale and limit and clears every channel's accumulator and previous error.
`default_nettype none

module multi_channel_incremental_pi_speed (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write port.
    input  wire logic                             cfg_wen,
    input  wire logic [mcips_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mcips_pkg::GAIN_W-1:0]     cfg_data,
    // Input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [mcips_pkg::S_TDATA_W-1:0]  s_tdata,  // encoder_count[15:0], target_speed[39:16]
    input  wire logic [mcips_pkg::CH_W-1:0]       s_tuser,  // channel[1:0]
    // Output stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [mcips_pkg::M_TDATA_W-1:0]       m_tdata,  // measured_speed[31:0], drive[47:32]
    output logic [mcips_pkg::CH_W-1:0]            m_tuser   // out_channel[1:0]
);
    import mcips_pkg::*;

    // Sequencer codes.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPD   = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_KP    = 4'd4;
    localparam logic [3:0] S_KI    = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_CLAMP = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration registers.
    logic [GAIN_W-1:0]  kp_reg;
    logic [GAIN_W-1:0]  ki_reg;
    logic [GAIN_W-1:0]  scale_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Per-channel state.
    logic signed [ACC_W-1:0] acc_mem [CHANNELS];
    logic signed [ERR_W-1:0] prev_mem [CHANNELS];

    // Item registers.
    logic [CH_W-1:0]            ch_reg;
    logic signed [TARGET_W-1:0] target_reg;
    logic signed [SPEED_W-1:0]  speed_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [ACC_W-1:0]    acc_new_reg;

    // Shared multiplier.
    logic signed [MUL_A_W-1:0] mul_a_reg;
    logic signed [MUL_B_W-1:0] mul_b_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;

    // Output register.
    logic                       out_valid_reg;
    logic [CH_W-1:0]            out_ch_reg;
    logic [SPEED_W-1:0]         out_speed_reg;
    logic [DRIVE_W-1:0]         out_drive_reg;

    logic                       accept;
    logic                       out_load;
    logic                       ch_ok;
    logic signed [ERR_W:0]      err_wide;
    logic signed [SUM_W-1:0]    lim_pos;
    logic signed [SUM_W-1:0]    lim_neg;
    logic signed [SUM_W-1:0]    clamped;
    logic signed [ACC_W-1:0]    acc_round;
    logic [DRIVE_W-1:0]         drive_val;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign ch_ok    = (int'(ch_reg) < CHANNELS);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tdata  = {out_drive_reg, out_speed_reg};

    // One product per cycle from the operand registers.
    assign prod_next = mul_a_reg * mul_b_reg;

    // Error: target minus measured speed, saturated.
    assign err_wide = {{(ERR_W + 1 - TARGET_W){target_reg[TARGET_W-1]}}, target_reg}
                    - {prod_reg[SPEED_W-1], prod_reg[SPEED_W-1:0]};

    // Symmetric clamp of the new sum to the drive limit.
    assign lim_pos = {{(SUM_W - LIMIT_W - 16){1'b0}}, limit_reg, 16'b0};
    assign lim_neg = -lim_pos;
    always_comb
    begin
        if (sum_reg > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (sum_reg < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = sum_reg;
        end
    end

    // Accumulator to drive, rounding toward zero.
    assign acc_round = acc_new_reg + (acc_new_reg[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
    assign drive_val = ch_ok ? DRIVE_W'(acc_round >>> 8) : '0;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_SPD;
            S_SPD:   state_next = S_ERR;
            S_ERR:   state_next = ch_ok ? S_DIFF : S_DONE;
            S_DIFF:  state_next = S_KP;
            S_KP:    state_next = S_KI;
            S_KI:    state_next = S_SUM;
            S_SUM:   state_next = S_CLAMP;
            S_CLAMP: state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= KP_RESET;
            ki_reg    <= KI_RESET;
            scale_reg <= SCALE_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_KP_GAIN:     kp_reg    <= cfg_data;
                REG_KI_GAIN:     ki_reg    <= cfg_data;
                REG_SPEED_SCALE: scale_reg <= cfg_data;
                REG_DRIVE_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Datapath: operand loads for the shared multiplier and the accumulation.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_reg     <= s_tuser;
                    target_reg <= s_tdata[COUNT_W +: TARGET_W];
                    mul_a_reg  <= {1'b0, scale_reg};
                    mul_b_reg  <= {{(MUL_B_W - COUNT_W){s_tdata[COUNT_W-1]}},
                                   s_tdata[COUNT_W-1:0]};
                end
            end
            S_ERR:
            begin
                speed_reg <= prod_reg[SPEED_W-1:0];
                err_reg   <= sat32(err_wide);
            end
            S_DIFF:
            begin
                mul_a_reg <= {1'b0, kp_reg};
                mul_b_reg <= {{2{err_reg[ERR_W-1]}}, err_reg}
                           - {{2{prev_mem[ch_reg][ERR_W-1]}}, prev_mem[ch_reg]};
            end
            S_KP:
            begin
                mul_a_reg <= {1'b0, ki_reg};
                mul_b_reg <= {{2{err_reg[ERR_W-1]}}, err_reg};
            end
            S_KI:
            begin
                sum_reg <= {{(SUM_W - ACC_W - 8){acc_mem[ch_reg][ACC_W-1]}},
                            acc_mem[ch_reg], 8'b0}
                         + {prod_reg[PROD_W-1], prod_reg};
            end
            S_SUM:
            begin
                sum_reg <= sum_reg + {prod_reg[PROD_W-1], prod_reg};
            end
            S_CLAMP:
            begin
                acc_new_reg <= clamped[ACC_W+7:8];
            end
            default: ;
        endcase
    end

    // Per-channel state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                acc_mem[i]  <= '0;
                prev_mem[i] <= '0;
            end
        end
        else if (state_reg == S_CLAMP)
        begin
            acc_mem[ch_reg]  <= clamped[ACC_W+7:8];
            prev_mem[ch_reg] <= err_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch_reg    <= ch_reg;
            out_speed_reg <= speed_reg;
            out_drive_reg <= drive_val;
        end
    end

    // The sequencer is busy for the cycle after an accepted transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input accepted while sequencer busy");

    // A new result is only presented from the final step.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_DONE)
        else $error("result presented outside the final step");

    // The accumulator stays within the drive limit after the clamp.
    a_acc_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && ch_ok) |->
            ($signed({{(SUM_W - ACC_W - 8){acc_new_reg[ACC_W-1]}}, acc_new_reg, 8'b0})
                 <= lim_pos &&
             $signed({{(SUM_W - ACC_W - 8){acc_new_reg[ACC_W-1]}}, acc_new_reg, 8'b0})
                 >= lim_neg))
        else $error("accumulator beyond drive limit");

    // Truncation toward zero never yields the most negative drive code.
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_drive_reg != {1'b1, {(DRIVE_W-1){1'b0}}})
        else $error("drive out of range");

endmodule

`default_nettype wire
